@@ hw/rtl/rfifo_pkg.sv @@
package rfifo_pkg;

	localparam int unsigned OP_W     = 3;
	localparam int unsigned POS_W    = 4;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 5;

	localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
	localparam logic [OP_W-1:0] OP_POP    = 3'd1;
	localparam logic [OP_W-1:0] OP_READ   = 3'd2;
	localparam logic [OP_W-1:0] OP_WRITE  = 3'd3;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd4;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [POS_W-1:0]  position;
		logic [DATA_W-1:0] data_in;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0]   read_data;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
	} rsp_t;

endpackage

@@ hw/rtl/rfifo_req_if.sv @@
interface rfifo_req_if import rfifo_pkg::*; ();

	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

@@ hw/rtl/rfifo_rsp_if.sv @@
interface rfifo_rsp_if import rfifo_pkg::*; ();

	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

@@ hw/rtl/ring_fifo_with_indexed_access.sv @@
// Ring FIFO with indexed access. Each request beat on req is one operation:
// push, pop, read, write, insert or delete at a position counted from the
// head. Each request produces exactly one response beat on rsp with the read
// data, a status (ok, full, empty, out of range) and the count afterwards.
// Refused requests change nothing and return zero data.
// Sequencing: a request is taken only while the sequencer is idle. Push,
// write and refused requests go from the execute state to the done state;
// pop and read first wait for one registered memory read, delete adds one
// shift step per entry moved forward, and insert adds one shift step per
// entry moved back and a final write of the new entry. The shifts are
// bounded by the single storage RAM, which does one read and one write per
// cycle.
// The response sits in an output register; a new request is accepted while
// it waits, and a finished operation holds in its last state until the
// receiver takes the pending beat.
// Reset empties the queue and clears the head; storage contents are not
// cleared and no clearing pass is needed.
module ring_fifo_with_indexed_access import rfifo_pkg::*; #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	rfifo_req_if.sink   req,
	rfifo_rsp_if.source rsp
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FW = $clog2(DEPTH + 1);
	localparam int unsigned CW = (FW > POS_W) ? FW : POS_W;
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [FW:0]   DEPTH_X   = (FW + 1)'(DEPTH);
	localparam logic [FW-1:0] DEPTH_F   = FW'(DEPTH);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_RDWAIT = 3'd2;
	localparam logic [2:0] S_SHIFT  = 3'd3;
	localparam logic [2:0] S_INSFIN = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0]            state_q;
	logic [OP_W-1:0]       op_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_W-1:0]     din_q;
	logic [AW-1:0]         head_q;
	logic [FW-1:0]         fill_q;
	logic [AW-1:0]         rd_slot_q;
	logic [AW-1:0]         wr_slot_q;
	logic [FW-1:0]         cnt_q;
	logic [DATA_W-1:0]     res_data_q;
	logic [STATUS_W-1:0]   res_status_q;
	rsp_t                  out_q;
	logic                  out_valid_q;

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] mem_rd_q;

	logic                  mem_we;
	logic [AW-1:0]         mem_wa;
	logic [AW-1:0]         mem_ra;
	logic [DATA_WIDTH-1:0] mem_wd;

	logic [FW-1:0]         slot_idx;
	logic [FW:0]           slot_sum;
	logic [AW-1:0]         slot;
	logic [AW-1:0]         slot_inc;
	logic [AW-1:0]         rd_step;
	logic [STATUS_W-1:0]   exec_status;
	logic [CW-1:0]         pos_w;
	logic [CW-1:0]         fill_w;
	logic                  out_free;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x);
		return (x == LAST_SLOT) ? '0 : x + AW'(1);
	endfunction

	function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] x);
		return (x == '0) ? LAST_SLOT : x - AW'(1);
	endfunction

	assign pos_w  = CW'(pos_q);
	assign fill_w = CW'(fill_q);

	// Shared slot unit: physical slot of a logical index. The index never
	// reaches DEPTH on a used path, so one conditional subtract wraps it.
	always_comb begin
		case (op_q)
			OP_PUSH:   slot_idx = fill_q;
			OP_POP:    slot_idx = '0;
			OP_INSERT: slot_idx = fill_q - FW'(1);
			default:   slot_idx = FW'(pos_q);
		endcase
		slot_sum = (FW + 1)'(head_q) + (FW + 1)'(slot_idx);
		if (slot_sum >= DEPTH_X) begin
			slot = AW'(slot_sum - DEPTH_X);
		end else begin
			slot = AW'(slot_sum);
		end
		slot_inc = wrap_inc(slot);
	end

	always_comb begin
		unique case (op_q)
			OP_PUSH: begin
				exec_status = (fill_q == DEPTH_F) ? ST_FULL : ST_OK;
			end
			OP_POP: begin
				exec_status = (fill_q == '0) ? ST_EMPTY : ST_OK;
			end
			OP_READ, OP_WRITE, OP_DELETE: begin
				if (fill_q == '0) begin
					exec_status = ST_EMPTY;
				end else if (pos_w >= fill_w) begin
					exec_status = ST_RANGE;
				end else begin
					exec_status = ST_OK;
				end
			end
			OP_INSERT: begin
				if (fill_q == DEPTH_F) begin
					exec_status = ST_FULL;
				end else if (pos_w >= fill_w) begin
					exec_status = ST_RANGE;
				end else begin
					exec_status = ST_OK;
				end
			end
			default: exec_status = ST_RANGE;
		endcase
	end

	assign rd_step = (op_q == OP_DELETE) ? wrap_inc(rd_slot_q) : wrap_dec(rd_slot_q);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = slot;
		mem_wd = DATA_WIDTH'(din_q);
		mem_ra = slot;
		unique case (state_q)
			S_EXEC: begin
				mem_we = (exec_status == ST_OK) && (op_q == OP_PUSH || op_q == OP_WRITE);
				if (op_q == OP_DELETE) begin
					mem_ra = slot_inc;
				end
			end
			S_SHIFT: begin
				mem_we = 1'b1;
				mem_wa = wr_slot_q;
				mem_wd = mem_rd_q;
				mem_ra = rd_step;
			end
			S_INSFIN: begin
				mem_we = 1'b1;
				mem_wa = wr_slot_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		mem_rd_q <= mem_q[mem_ra];
	end

	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;
	assign out_free    = !out_valid_q || rsp.ready;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			op_q  <= req.payload.operation;
			pos_q <= req.payload.position;
			din_q <= req.payload.data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			fill_q       <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			rd_slot_q    <= '0;
			wr_slot_q    <= '0;
			cnt_q        <= '0;
			res_data_q   <= '0;
			res_status_q <= ST_OK;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_data_q   <= '0;
					res_status_q <= exec_status;
					state_q      <= S_DONE;
					if (exec_status == ST_OK) begin
						case (op_q)
							OP_PUSH: fill_q <= fill_q + FW'(1);
							OP_POP: begin
								head_q  <= wrap_inc(head_q);
								fill_q  <= fill_q - FW'(1);
								state_q <= S_RDWAIT;
							end
							OP_READ: state_q <= S_RDWAIT;
							OP_DELETE: begin
								wr_slot_q <= slot;
								rd_slot_q <= slot_inc;
								cnt_q     <= FW'(fill_w - pos_w) - FW'(1);
								if (FW'(fill_w - pos_w) == FW'(1)) begin
									fill_q <= fill_q - FW'(1);
								end else begin
									state_q <= S_SHIFT;
								end
							end
							OP_INSERT: begin
								rd_slot_q <= slot;
								wr_slot_q <= slot_inc;
								cnt_q     <= FW'(fill_w - pos_w);
								state_q   <= S_SHIFT;
							end
							default: ;
						endcase
					end
				end
				S_RDWAIT: begin
					res_data_q <= DATA_W'(mem_rd_q);
					state_q    <= S_DONE;
				end
				S_SHIFT: begin
					// Each beat of the shift copies one entry and reads the next.
					wr_slot_q <= rd_slot_q;
					rd_slot_q <= rd_step;
					cnt_q     <= cnt_q - FW'(1);
					if (cnt_q == FW'(1)) begin
						if (op_q == OP_DELETE) begin
							fill_q  <= fill_q - FW'(1);
							state_q <= S_DONE;
						end else begin
							state_q <= S_INSFIN;
						end
					end
				end
				S_INSFIN: begin
					fill_q  <= fill_q + FW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_q.read_data <= res_data_q;
						out_q.status    <= res_status_q;
						out_q.count     <= COUNT_W'(fill_q);
						out_valid_q     <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ tb/sv/tb_ring_fifo_with_indexed_access.sv @@
module tb_ring_fifo_with_indexed_access import rfifo_pkg::*; ();

	localparam int unsigned QDEPTH     = 16;
	localparam int unsigned LONG_HOLD  = 300;
	localparam int unsigned STALL_MAX  = 2000;
	localparam int unsigned TAIL_WAIT  = QDEPTH + 8;

	// Codes the block does not define; both must be refused as out of range.
	localparam logic [OP_W-1:0] OP_UNDEF6 = 3'd6;
	localparam logic [OP_W-1:0] OP_UNDEF7 = 3'd7;

	typedef enum int unsigned {LEAN_GROW, LEAN_SHRINK, LEAN_EVEN} lean_t;

	logic clk = 1'b0;
	logic arst_n;

	rfifo_req_if req_bus ();
	rfifo_rsp_if rsp_bus ();

	ring_fifo_with_indexed_access #(
		.DEPTH      (QDEPTH),
		.DATA_WIDTH (DATA_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	always #5 clk = ~clk;

	// Mirror of the queue contents, used to predict each response beat.
	logic [DATA_W-1:0] q_store [QDEPTH];
	int unsigned       q_head;
	int unsigned       q_fill;

	rsp_t        pending_rsp [$];
	int unsigned errors;
	int unsigned stall_cycles;
	bit          gaps_en;
	bit          hold_rsp;

	function automatic int unsigned ring_slot(input int unsigned lpos);
		return (q_head + lpos) % QDEPTH;
	endfunction

	function automatic rsp_t ring_update(input req_t r);
		rsp_t        o;
		int unsigned p;
		int unsigned i;
		o = '0;
		p = 32'(r.position);
		case (r.operation)
			OP_PUSH: begin
				if (q_fill >= QDEPTH) begin
					o.status = ST_FULL;
				end else begin
					q_store[ring_slot(q_fill)] = r.data_in;
					q_fill++;
				end
			end
			OP_POP: begin
				if (q_fill == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.read_data = q_store[q_head];
					q_head = (q_head + 1) % QDEPTH;
					q_fill--;
				end
			end
			OP_READ, OP_WRITE, OP_DELETE: begin
				if (q_fill == 0) begin
					o.status = ST_EMPTY;
				end else if (p >= q_fill) begin
					o.status = ST_RANGE;
				end else if (r.operation == OP_READ) begin
					o.read_data = q_store[ring_slot(p)];
				end else if (r.operation == OP_WRITE) begin
					q_store[ring_slot(p)] = r.data_in;
				end else begin
					for (i = p; i + 1 < q_fill; i++)
						q_store[ring_slot(i)] = q_store[ring_slot(i + 1)];
					q_fill--;
				end
			end
			OP_INSERT: begin
				// The full check wins over the range check.
				if (q_fill >= QDEPTH) begin
					o.status = ST_FULL;
				end else if (p >= q_fill) begin
					o.status = ST_RANGE;
				end else begin
					for (i = q_fill; i > p; i--)
						q_store[ring_slot(i)] = q_store[ring_slot(i - 1)];
					q_store[ring_slot(p)] = r.data_in;
					q_fill++;
				end
			end
			default: begin
				o.status = ST_RANGE;
			end
		endcase
		o.count = COUNT_W'(q_fill);
		return o;
	endfunction

	function automatic req_t mk_req(input logic [OP_W-1:0] op, input int unsigned pos,
			input logic [DATA_W-1:0] data);
		req_t r;
		r.operation = op;
		r.position  = POS_W'(pos);
		r.data_in   = data;
		return r;
	endfunction

	function automatic req_t rand_req(input lean_t lean);
		req_t        r;
		int unsigned roll;
		int unsigned grow_w;
		int unsigned shrink_w;
		grow_w   = (lean == LEAN_GROW) ? 60 : (lean == LEAN_SHRINK) ? 15 : 36;
		shrink_w = (lean == LEAN_GROW) ? 15 : (lean == LEAN_SHRINK) ? 55 : 32;
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			r.operation = $urandom_range(0, 1) ? OP_UNDEF7 : OP_UNDEF6;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < grow_w)
				r.operation = $urandom_range(0, 1) ? OP_INSERT : OP_PUSH;
			else if (roll < grow_w + shrink_w)
				r.operation = $urandom_range(0, 1) ? OP_DELETE : OP_POP;
			else
				r.operation = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
		end
		// Mostly valid positions, with some that are out of range.
		if (q_fill != 0 && $urandom_range(0, 9) != 0)
			r.position = POS_W'($urandom_range(0, q_fill - 1));
		else
			r.position = POS_W'($urandom_range(0, QDEPTH - 1));
		case ($urandom_range(0, 9))
			0:       r.data_in = '0;
			1:       r.data_in = '1;
			default: r.data_in = $urandom;
		endcase
		return r;
	endfunction

	// Offers one beat and returns at the edge where it is taken. Valid stays
	// high so that a following beat can go out back to back.
	task automatic send_req(input req_t r);
		if (gaps_en && $urandom_range(0, 3) == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_bus.valid   <= 1'b1;
		req_bus.payload <= r;
		do @(posedge clk); while (!req_bus.ready);
		pending_rsp.push_back(ring_update(r));
	endtask

	task automatic wait_drained();
		req_bus.valid <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
	endtask

	task automatic test_empty_queue();
		send_req(mk_req(OP_POP, 0, '0));
		send_req(mk_req(OP_READ, 0, '0));
		send_req(mk_req(OP_WRITE, 0, '1));
		send_req(mk_req(OP_DELETE, 0, '0));
		send_req(mk_req(OP_INSERT, 0, 32'h1234_5678));
		send_req(mk_req(OP_UNDEF6, 15, '1));
		send_req(mk_req(OP_UNDEF7, 0, '1));
	endtask

	task automatic test_fill_to_full();
		send_req(mk_req(OP_PUSH, 0, '0));
		send_req(mk_req(OP_PUSH, 15, '1));
		repeat (QDEPTH - 2) send_req(mk_req(OP_PUSH, $urandom_range(0, 15), $urandom));
		send_req(mk_req(OP_PUSH, 0, 32'hdead_beef));
		send_req(mk_req(OP_INSERT, 0, 32'hdead_beef));
	endtask

	task automatic test_position_edges();
		send_req(mk_req(OP_READ, 15, '0));
		send_req(mk_req(OP_WRITE, 15, 32'h8000_0001));
		send_req(mk_req(OP_DELETE, 0, '0));
		send_req(mk_req(OP_INSERT, 15, 32'h5555_aaaa));
		send_req(mk_req(OP_INSERT, 0, 32'haaaa_5555));
	endtask

	task automatic test_output_backpressure();
		gaps_en  = 1'b0;
		hold_rsp = 1'b1;
		repeat (24) send_req(rand_req(LEAN_EVEN));
		wait_drained();
	endtask

	task automatic test_drain_pause();
		gaps_en = 1'b1;
		repeat (6) send_req(rand_req(LEAN_EVEN));
		wait_drained();
		repeat (6) send_req(rand_req(LEAN_SHRINK));
	endtask

	task automatic test_random_ops(input int unsigned chunks);
		lean_t lean;
		repeat (chunks) begin
			lean    = lean_t'($urandom_range(0, 2));
			gaps_en = ($urandom_range(0, 2) != 0);
			repeat (40) send_req(rand_req(lean));
		end
	endtask

	task automatic test_no_idle_tail();
		gaps_en = 1'b0;
		repeat (150) send_req(rand_req(lean_t'($urandom_range(0, 2))));
	endtask

	// Response side: random ready bursts, plus one long hold on request.
	initial begin : rsp_side
		int unsigned hold;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_bus.ready <= 1'b0;
				hold = LONG_HOLD;
				while (hold != 0) begin
					@(posedge clk);
					hold--;
				end
				hold_rsp = 1'b0;
			end else if (gaps_en && $urandom_range(0, 4) == 0) begin
				rsp_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 6) - 1) @(posedge clk);
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected response beat: %p", rsp_bus.payload);
				errors++;
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (rsp_bus.payload.read_data !== exp_rsp.read_data) begin
					$error("read_data: expected %h, actual %h",
						exp_rsp.read_data, rsp_bus.payload.read_data);
					errors++;
				end
				if (rsp_bus.payload.status !== exp_rsp.status) begin
					$error("status: expected %0d, actual %0d",
						exp_rsp.status, rsp_bus.payload.status);
					errors++;
				end
				if (rsp_bus.payload.count !== exp_rsp.count) begin
					$error("count: expected %0d, actual %0d",
						exp_rsp.count, rsp_bus.payload.count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_MAX) begin
			$display("ring_fifo_with_indexed_access regression: fail");
			$finish;
		end
	end

	initial begin
		errors          = 0;
		gaps_en         = 1'b0;
		hold_rsp        = 1'b0;
		q_head          = 0;
		q_fill          = 0;
		foreach (q_store[i]) q_store[i] = '0;
		arst_n          <= 1'b0;
		req_bus.valid   <= 1'b0;
		req_bus.payload <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_queue();
		test_fill_to_full();
		test_position_edges();
		test_output_backpressure();
		test_drain_pause();
		test_random_ops(39);
		test_no_idle_tail();

		wait_drained();
		repeat (TAIL_WAIT) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0) begin
			$display("ring_fifo_with_indexed_access regression: pass");
		end else begin
			$display("ring_fifo_with_indexed_access regression: fail");
		end
		$finish;
	end

endmodule
